// ----- rtl/core/bilinear_texture_sampler_unit_macros.svh -----
// Assertion macros for the bilinear texture sampler.
// Included by the top level, the only file that checks its own logic; no other dependencies.
`ifndef BILINEAR_TEXTURE_SAMPLER_UNIT_MACROS_SVH
`define BILINEAR_TEXTURE_SAMPLER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check with reset disable, clock and reset given by the caller
`define BTS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check on the block's own clk_i / rst_ni
`define BTS_ASSERT(lbl, prop, msg) \
  `BTS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define BTS_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define BTS_ASSERT(lbl, prop, msg)

`endif

`endif

// ----- rtl/core/bts_pkg.sv -----
// Shared constants, codes and payload types of the bilinear texture sampler.
// Used by every module under rtl/core; depends on nothing.
package bts_pkg;

  // Store geometry and field widths
  localparam int unsigned MaxWidth    = 256;
  localparam int unsigned MaxHeight   = 256;
  localparam int unsigned ChanBits    = 16;
  localparam int unsigned NumChan     = 3;
  localparam int unsigned XBits       = $clog2(MaxWidth);
  localparam int unsigned YBits       = $clog2(MaxHeight);
  localparam int unsigned AddrBits    = XBits + YBits;
  localparam int unsigned Depth       = MaxWidth * MaxHeight;
  localparam int unsigned SizeBits    = 9;
  localparam int unsigned CoordBits   = 24;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned ScaleFrac   = 8;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 9;
  localparam int unsigned InDataBits  = 168;
  localparam int unsigned OutDataBits = NumChan * ChanBits;

  // Item kind carried on tuser
  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_e;

  // Addressing mode
  typedef enum logic {
    WRAP_CLAMP = 1'b0,
    WRAP_TILE  = 1'b1
  } wrap_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    REG_TEX_WIDTH  = 2'd0,
    REG_TEX_HEIGHT = 2'd1,
    REG_WRAP_MODE  = 2'd2
  } cfg_reg_e;

  typedef logic [ChanBits-1:0] chan_t;
  typedef chan_t [NumChan-1:0] rgb_t;   // [0] red, [1] green, [2] blue
  typedef logic [XBits-1:0]    xidx_t;
  typedef logic [YBits-1:0]    yidx_t;
  typedef logic [FracBits-1:0] weight_t;

  // Effective texture size (1..max) and mode
  typedef struct packed {
    logic [SizeBits-1:0] width;
    logic [SizeBits-1:0] height;
    wrap_e               wrap;
  } cfg_t;

  // One input request
  typedef struct packed {
    func_e                 func;
    xidx_t                 texel_x;
    yidx_t                 texel_y;
    rgb_t                  texel;
    logic [CoordBits-1:0]  coord_u;
    logic [CoordBits-1:0]  coord_v;
    logic                  use_texture;
    rgb_t                  scale;
  } req_t;

  // Request after addressing, ready for the texel fetch
  typedef struct packed {
    func_e    func;
    xidx_t    x0;
    xidx_t    x1;
    yidx_t    y0;
    yidx_t    y1;
    weight_t  frac_s;
    weight_t  frac_t;
    xidx_t    texel_x;
    yidx_t    texel_y;
    rgb_t     texel;
    logic     use_texture;
    rgb_t     scale;
  } fetch_t;

  // Four fetched texels with weights and scale
  typedef struct packed {
    rgb_t    t00;
    rgb_t    t10;
    rgb_t    t01;
    rgb_t    t11;
    weight_t frac_s;
    weight_t frac_t;
    logic    use_texture;
    rgb_t    scale;
  } quad_t;

endpackage

// ----- rtl/core/bilinear_texture_sampler_unit.sv -----
// Bilinear texture sampler with tile / clamp addressing: top level.
// Uses bts_pkg, bts_coord, bts_texmem, bts_filter and the assertion macros header.
//
// The sampler takes one request per clock while the output is not stalled,
// a texel write or a sample, and gives one result per sample through two
// coordinate stages (scale, floor, wrap or clamp), one texel-fetch stage and
// five filter stages, the last of which is the output register. The rate of
// one request per clock is set by the texel store, held as two 64K-entry
// copies that each give two registered reads and take one write per clock,
// so a whole 2x2 footprint is read at once. A write lands in the store in
// the fetch stage, so a sample accepted right after it sees the new texel.
// The store is not cleared at reset: only texels that have been written may
// be sampled. Size and mode registers may be written only while the sampler
// holds no request.
`include "bilinear_texture_sampler_unit_macros.svh"

module bilinear_texture_sampler_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [bts_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [bts_pkg::CfgDataBits-1:0]  cfg_data_i,
  // Request stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata, low bit up: texel_x[7:0], texel_y[15:8], texel_red[31:16],
  // texel_green[47:32], texel_blue[63:48], coord_u[87:64], coord_v[111:88],
  // use_texture[112], scale_red[128:113], scale_green[144:129],
  // scale_blue[160:145], zero pad[167:161]
  input  logic [bts_pkg::InDataBits-1:0]   s_axis_tdata,
  // tuser: func[0]
  input  logic                             s_axis_tuser,
  // Result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata, low bit up: out_red[15:0], out_green[31:16], out_blue[47:32]
  output logic [bts_pkg::OutDataBits-1:0]  m_axis_tdata
);
  import bts_pkg::*;

  localparam logic [SizeBits-1:0] MaxW = SizeBits'(MaxWidth);
  localparam logic [SizeBits-1:0] MaxH = SizeBits'(MaxHeight);

  logic [SizeBits-1:0] width_q, height_q;
  wrap_e               wrap_q;
  cfg_t                cfg;
  req_t                req;
  logic                fetch_valid, fetch_ready, quad_valid, quad_ready;
  fetch_t              fetch;
  quad_t               quad;
  rgb_t                out_rgb;

  // Size register to effective size: zero acts as one, above max as max
  function automatic logic [SizeBits-1:0] eff_size(
    input logic [SizeBits-1:0] r,
    input logic [SizeBits-1:0] mx
  );
    logic [SizeBits-1:0] n;
    n = r;
    if (r == '0)    n = SizeBits'(1);
    else if (r > mx) n = mx;
    return n;
  endfunction

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= MaxW;
      height_q <= MaxH;
      wrap_q   <= WRAP_TILE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TEX_WIDTH:  width_q  <= cfg_data_i;
        REG_TEX_HEIGHT: height_q <= cfg_data_i;
        REG_WRAP_MODE:  wrap_q   <= wrap_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  assign cfg.width  = eff_size(width_q, MaxW);
  assign cfg.height = eff_size(height_q, MaxH);
  assign cfg.wrap   = wrap_q;

  // Unpack the request
  always_comb begin
    req.func        = func_e'(s_axis_tuser);
    req.texel_x     = s_axis_tdata[7:0];
    req.texel_y     = s_axis_tdata[15:8];
    req.texel       = s_axis_tdata[63:16];
    req.coord_u     = s_axis_tdata[87:64];
    req.coord_v     = s_axis_tdata[111:88];
    req.use_texture = s_axis_tdata[112];
    req.scale       = s_axis_tdata[160:113];
  end

  bts_coord u_coord (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_req_i    (req),
    .out_valid_o (fetch_valid),
    .out_ready_i (fetch_ready),
    .out_fetch_o (fetch)
  );

  bts_texmem u_texmem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fetch_valid),
    .in_ready_o  (fetch_ready),
    .in_fetch_i  (fetch),
    .out_valid_o (quad_valid),
    .out_ready_i (quad_ready),
    .out_quad_o  (quad)
  );

  bts_filter u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (quad_valid),
    .in_ready_o  (quad_ready),
    .in_quad_i   (quad),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rgb_o   (out_rgb)
  );

  assign m_axis_tdata = out_rgb;

  // Checks
  `BTS_ASSERT(a_ready_chain, m_axis_tready |-> s_axis_tready, "sink ready did not open input")
  `BTS_ASSERT(a_eff_size, (cfg.width != '0) && (cfg.width <= MaxW) && (cfg.height != '0) && (cfg.height <= MaxH), "effective size out of range")
  `BTS_ASSERT(a_no_write_result, $rose(quad_valid) |-> $past(fetch_valid) && $past(fetch.func == FUNC_SAMPLE), "fetch stage filled without a sample")

endmodule

// ----- rtl/core/bts_coord.sv -----
// Coordinate stages: scale u/v by texture size, floor, then wrap or clamp.
// Two register stages; depends on bts_pkg.
module bts_coord (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bts_pkg::cfg_t   cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bts_pkg::req_t   in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bts_pkg::fetch_t out_fetch_o
);
  import bts_pkg::*;

  localparam int unsigned ProdBits     = CoordBits + SizeBits;
  localparam int unsigned IdxBits      = ProdBits - FracBits;
  localparam int unsigned FracProdBits = FracBits + SizeBits;

  logic                       va_q, vb_q, en_a, en_b;
  req_t                       req_a_q;
  logic signed [ProdBits-1:0] pu_d, pv_d, pu_a_q, pv_a_q;
  logic [FracProdBits-1:0]    ru_d, rv_d, ru_a_q, rv_a_q;
  logic [2*SizeBits-1:0]      pair_u, pair_v;
  fetch_t                     fetch_d, fetch_q;

  // Neighbor pair {hi, lo} along one axis. modv is the floor index mod n.
  function automatic logic [2*SizeBits-1:0] axis_pair(
    input logic signed [IdxBits-1:0] idx,
    input logic [SizeBits-1:0]       modv,
    input logic [SizeBits-1:0]       n,
    input wrap_e                     mode
  );
    logic [SizeBits-1:0]       lo, hi, nm1, inc;
    logic signed [IdxBits-1:0] ns;
    nm1 = n - 1'b1;
    ns  = $signed({{(IdxBits-SizeBits){1'b0}}, n});
    inc = modv + 1'b1;
    if (mode == WRAP_TILE) begin
      lo = modv;
      hi = (inc == n) ? '0 : inc;
    end else begin
      if (idx < 0)         lo = '0;
      else if (idx >= ns)  lo = nm1;
      else                 lo = idx[SizeBits-1:0];
      if (idx < -1)            hi = '0;
      else if (idx >= ns - 1)  hi = nm1;
      else                     hi = SizeBits'(idx + 1);
    end
    return {hi, lo};
  endfunction

  // Handshake: a stage takes new data when empty or when it drains
  assign en_b       = !vb_q || out_ready_i;
  assign en_a       = !va_q || en_b;
  assign in_ready_o = en_a;

  // Stage A: full product for clamp, fraction product gives index mod n
  assign pu_d = $signed(in_req_i.coord_u) * $signed({1'b0, cfg_i.width});
  assign pv_d = $signed(in_req_i.coord_v) * $signed({1'b0, cfg_i.height});
  assign ru_d = in_req_i.coord_u[FracBits-1:0] * cfg_i.width;
  assign rv_d = in_req_i.coord_v[FracBits-1:0] * cfg_i.height;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) va_q <= in_valid_i;
      if (en_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && in_valid_i) begin
      req_a_q <= in_req_i;
      pu_a_q  <= pu_d;
      pv_a_q  <= pv_d;
      ru_a_q  <= ru_d;
      rv_a_q  <= rv_d;
    end
  end

  // Stage B: neighbor indexes and weights
  assign pair_u = axis_pair(pu_a_q[ProdBits-1:FracBits], ru_a_q[FracProdBits-1:FracBits],
                            cfg_i.width, cfg_i.wrap);
  assign pair_v = axis_pair(pv_a_q[ProdBits-1:FracBits], rv_a_q[FracProdBits-1:FracBits],
                            cfg_i.height, cfg_i.wrap);

  always_comb begin
    fetch_d.func        = req_a_q.func;
    fetch_d.x0          = pair_u[XBits-1:0];
    fetch_d.x1          = pair_u[SizeBits +: XBits];
    fetch_d.y0          = pair_v[YBits-1:0];
    fetch_d.y1          = pair_v[SizeBits +: YBits];
    fetch_d.frac_s      = pu_a_q[FracBits-1:0];
    fetch_d.frac_t      = pv_a_q[FracBits-1:0];
    fetch_d.texel_x     = req_a_q.texel_x;
    fetch_d.texel_y     = req_a_q.texel_y;
    fetch_d.texel       = req_a_q.texel;
    fetch_d.use_texture = req_a_q.use_texture;
    fetch_d.scale       = req_a_q.scale;
  end

  always_ff @(posedge clk_i) begin
    if (en_b && va_q) fetch_q <= fetch_d;
  end

  assign out_valid_o = vb_q;
  assign out_fetch_o = fetch_q;

endmodule

// ----- rtl/core/bts_texmem.sv -----
// Texel store: two copies, one write port each, two registered read ports each.
// One register stage; depends on bts_pkg.
module bts_texmem (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bts_pkg::fetch_t in_fetch_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bts_pkg::quad_t  out_quad_o
);
  import bts_pkg::*;

  // Copy a serves the upper row, copy b the lower row of the 2x2 footprint
  rgb_t                mem_a [Depth];
  rgb_t                mem_b [Depth];
  logic                v_q, en, wr_en;
  logic [AddrBits-1:0] wr_addr, a00, a10, a01, a11;
  rgb_t                t00_q, t10_q, t01_q, t11_q;
  weight_t             fs_q, ft_q;
  logic                use_q;
  rgb_t                scale_q;

  assign en         = !v_q || out_ready_i;
  assign in_ready_o = en;

  assign wr_en   = en && in_valid_i && (in_fetch_i.func == FUNC_WRITE);
  assign wr_addr = {in_fetch_i.texel_y, in_fetch_i.texel_x};
  assign a00     = {in_fetch_i.y0, in_fetch_i.x0};
  assign a10     = {in_fetch_i.y0, in_fetch_i.x1};
  assign a01     = {in_fetch_i.y1, in_fetch_i.x0};
  assign a11     = {in_fetch_i.y1, in_fetch_i.x1};

  // Write port: both copies take every texel write
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_a[wr_addr] <= in_fetch_i.texel;
      mem_b[wr_addr] <= in_fetch_i.texel;
    end
  end

  // Read ports, data registered and held while stalled
  always_ff @(posedge clk_i) begin
    if (en) begin
      t00_q <= mem_a[a00];
      t10_q <= mem_a[a10];
      t01_q <= mem_b[a01];
      t11_q <= mem_b[a11];
    end
  end

  // Writes end here; only samples move on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i && (in_fetch_i.func == FUNC_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fs_q    <= in_fetch_i.frac_s;
      ft_q    <= in_fetch_i.frac_t;
      use_q   <= in_fetch_i.use_texture;
      scale_q <= in_fetch_i.scale;
    end
  end

  always_comb begin
    out_quad_o.t00         = t00_q;
    out_quad_o.t10         = t10_q;
    out_quad_o.t01         = t01_q;
    out_quad_o.t11         = t11_q;
    out_quad_o.frac_s      = fs_q;
    out_quad_o.frac_t      = ft_q;
    out_quad_o.use_texture = use_q;
    out_quad_o.scale       = scale_q;
  end

  assign out_valid_o = v_q;

endmodule

// ----- rtl/core/bts_filter.sv -----
// Filter stages: horizontal blend, vertical blend, rounding, scale, saturate or scale-color pass-through.
// Five register stages, last one is the output register; depends on bts_pkg.
module bts_filter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bts_pkg::quad_t in_quad_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bts_pkg::rgb_t  out_rgb_o
);
  import bts_pkg::*;

  localparam int unsigned Stages     = 5;
  localparam int unsigned SideStages = Stages - 1;
  localparam int unsigned HBits      = ChanBits + FracBits;
  localparam int unsigned SumBits    = ChanBits + 2 * FracBits;
  localparam int unsigned ProdBits   = 2 * ChanBits;
  localparam int unsigned ShBits     = ProdBits + 1 - ScaleFrac;
  localparam logic [FracBits:0]   WeightOne = {1'b1, {FracBits{1'b0}}};
  localparam logic [SumBits-1:0]  BlendHalf = SumBits'(1) << (2 * FracBits - 1);
  localparam logic [ProdBits:0]   ScaleHalf = (ProdBits + 1)'(1) << (ScaleFrac - 1);

  logic [Stages-1:0]                 v_q;
  logic [Stages:0]                   en;
  logic                              use_q   [SideStages];
  rgb_t                              scale_q [SideStages];
  logic [FracBits:0]                 ws, wt;
  weight_t                           ft_q;
  logic [NumChan-1:0][HBits-1:0]     top_d, top_q, bot_d, bot_q;
  logic [NumChan-1:0][SumBits-1:0]   sum_d, sum_q;
  logic [NumChan-1:0][SumBits-1:0]   rnd;
  rgb_t                              f_d, f_q, out_d, out_q;
  logic [NumChan-1:0][ProdBits-1:0]  prod_d, prod_q;
  logic [NumChan-1:0][ProdBits:0]    rnd2;
  logic [NumChan-1:0][ShBits-1:0]    shr;

  // Stall chain: a stage moves when empty or when the next one moves
  always_comb begin
    en[Stages] = out_ready_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Scale and texture flag ride along
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      use_q[0]   <= in_quad_i.use_texture;
      scale_q[0] <= in_quad_i.scale;
    end
    for (int k = 1; k < SideStages; k++) begin
      if (en[k]) begin
        use_q[k]   <= use_q[k-1];
        scale_q[k] <= scale_q[k-1];
      end
    end
  end

  // Stage 0: blend along u
  assign ws = WeightOne - {1'b0, in_quad_i.frac_s};
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      top_d[c] = HBits'(in_quad_i.t00[c]) * HBits'(ws) +
                 HBits'(in_quad_i.t10[c]) * HBits'(in_quad_i.frac_s);
      bot_d[c] = HBits'(in_quad_i.t01[c]) * HBits'(ws) +
                 HBits'(in_quad_i.t11[c]) * HBits'(in_quad_i.frac_s);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      top_q <= top_d;
      bot_q <= bot_d;
      ft_q  <= in_quad_i.frac_t;
    end
  end

  // Stage 1: blend along v
  assign wt = WeightOne - {1'b0, ft_q};
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      sum_d[c] = SumBits'(top_q[c]) * SumBits'(wt) + SumBits'(bot_q[c]) * SumBits'(ft_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) sum_q <= sum_d;
  end

  // Stage 2: round Q0.32 weights back to Q8.8, half up
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      rnd[c] = sum_q[c] + BlendHalf;
      f_d[c] = rnd[c][SumBits-1:2*FracBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) f_q <= f_d;
  end

  // Stage 3: multiply by the scale color
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      prod_d[c] = ProdBits'(f_q[c]) * ProdBits'(scale_q[2][c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) prod_q <= prod_d;
  end

  // Stage 4: round, saturate, or pass the scale color through
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      rnd2[c] = {1'b0, prod_q[c]} + ScaleHalf;
      shr[c]  = rnd2[c][ProdBits:ScaleFrac];
      if (!use_q[3]) begin
        out_d[c] = scale_q[3][c];
      end else if (|shr[c][ShBits-1:ChanBits]) begin
        out_d[c] = '1;
      end else begin
        out_d[c] = shr[c][ChanBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) out_q <= out_d;
  end

  assign out_valid_o = v_q[Stages-1];
  assign out_rgb_o   = out_q;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Testbench for bilinear_texture_sampler_unit: texel writes and bilinear samples over
// several size and wrap settings, checked against a filter model kept here.
// Depends on bts_pkg and the sampler RTL only.
module tb;
  import bts_pkg::*;

  typedef logic [CoordBits-1:0] coord_t;

  // One row of the directed stimulus table
  typedef struct {
    req_t item;
    bit   typed;    // result below is written out by hand
    rgb_t result;
  } stim_row_t;

  localparam longint unsigned ONE_Q16 = 65536;
  localparam int FILL_LIMIT      = 64;    // regions up to this many texels are fully written
  localparam int RAND_PER_PHASE  = 46;
  localparam int PIPE_SETTLE     = 12;    // eight stages plus margin
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int HOLD_PHASE      = 4;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int NUM_PHASES      = 9;

  // Raw register values per phase; phase 0 runs on the reset values
  localparam logic [SizeBits-1:0] PHASE_W [NUM_PHASES] =
    '{9'd256, 9'd4, 9'd0, 9'd3, 9'd511, 9'd256, 9'd7, 9'd2, 9'd1};
  localparam logic [SizeBits-1:0] PHASE_H [NUM_PHASES] =
    '{9'd256, 9'd4, 9'd0, 9'd5, 9'd300, 9'd2, 9'd1, 9'd256, 9'd1};
  localparam wrap_e PHASE_MODE [NUM_PHASES] =
    '{WRAP_TILE, WRAP_CLAMP, WRAP_TILE, WRAP_TILE, WRAP_CLAMP, WRAP_TILE, WRAP_CLAMP,
      WRAP_TILE, WRAP_CLAMP};

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_index_i;
  logic [CfgDataBits-1:0] cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // tdata, low bit up: texel_x, texel_y, texel_red, texel_green, texel_blue,
  // coord_u, coord_v, use_texture, scale_red, scale_green, scale_blue, zero pad
  logic [InDataBits-1:0]  s_axis_tdata;
  // tuser: func
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // tdata, low bit up: out_red, out_green, out_blue
  logic [OutDataBits-1:0] m_axis_tdata;

  bilinear_texture_sampler_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Model state: texel store, which texels hold data, effective size and mode
  rgb_t  texel_mem     [Depth];
  bit    texel_written [Depth];
  int    cur_w = MaxWidth;
  int    cur_h = MaxHeight;
  bit    tile_mode = 1'b1;

  rgb_t      expected_rgb_q [$];
  stim_row_t directed_rows  [$];
  string     chan_name [NumChan] = '{"red", "green", "blue"};

  int errors = 0;
  int n_checked = 0;
  int n_writes = 0;
  int n_samples = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int idle_cycles = 0;
  bit hold_off_req = 1'b0;

  // ---------------------------------------------------------------------------
  // Filter model
  // ---------------------------------------------------------------------------

  function automatic int eff_size(logic [SizeBits-1:0] raw, int max_size);
    if (raw == 0) return 1;
    if (raw > max_size) return max_size;
    return int'(raw);
  endfunction

  // Wrap (non-negative modulo) or clamp an index into 0..n-1
  function automatic int edge_address(longint k, int n);
    longint m;
    if (tile_mode) begin
      m = k % longint'(n);
      if (m < 0) m += n;
      return int'(m);
    end
    if (k < 0) return 0;
    if (k > n - 1) return n - 1;
    return int'(k);
  endfunction

  // Scale a Q8.16 coordinate by n: floor gives the index pair, low bits the weight
  function automatic void axis_lookup(input coord_t c, input int n, output int a0,
                                      output int a1, output longint unsigned w);
    longint p;
    p = longint'($signed(c)) * longint'(n);
    w = p[FracBits-1:0];
    a0 = edge_address(p >>> FracBits, n);
    a1 = edge_address((p >>> FracBits) + 1, n);
  endfunction

  function automatic bit footprint_written(coord_t u, coord_t v);
    int x0, x1, y0, y1;
    longint unsigned s, t;
    axis_lookup(u, cur_w, x0, x1, s);
    axis_lookup(v, cur_h, y0, y1, t);
    return texel_written[y0*MaxWidth + x0] && texel_written[y0*MaxWidth + x1] &&
           texel_written[y1*MaxWidth + x0] && texel_written[y1*MaxWidth + x1];
  endfunction

  // Scale color if the texture is unused, else bilinear blend rounded to Q8.8, times scale, rounded and saturated
  function automatic rgb_t filtered_rgb(req_t r);
    int x0, x1, y0, y1;
    longint unsigned s, t, top, bot, sum, blend, scaled;
    rgb_t q00, q10, q01, q11, res;
    if (!r.use_texture) return r.scale;
    axis_lookup(r.coord_u, cur_w, x0, x1, s);
    axis_lookup(r.coord_v, cur_h, y0, y1, t);
    q00 = texel_mem[y0*MaxWidth + x0];
    q10 = texel_mem[y0*MaxWidth + x1];
    q01 = texel_mem[y1*MaxWidth + x0];
    q11 = texel_mem[y1*MaxWidth + x1];
    for (int c = 0; c < NumChan; c++) begin
      top = q00[c] * (ONE_Q16 - s) + q10[c] * s;
      bot = q01[c] * (ONE_Q16 - s) + q11[c] * s;
      sum = top * (ONE_Q16 - t) + bot * t;
      blend = (sum + (64'd1 << 31)) >> 32;
      scaled = (blend * r.scale[c] + 128) >> ScaleFrac;
      res[c] = (scaled > 64'hFFFF) ? '1 : chan_t'(scaled);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  function automatic chan_t chan_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return chan_t'($urandom_range(0, 16'h0200));
      default: return chan_t'($urandom);
    endcase
  endfunction

  // Mostly coordinates near a multiple of the size, so the footprint sits on
  // the tile seam or the clamp edge; sometimes any 24-bit value
  function automatic coord_t near_seam_coord(int n);
    longint k, num;
    coord_t c;
    if ($urandom_range(0, 3) == 0) return coord_t'($urandom);
    k = longint'(n) * (longint'($urandom_range(0, 6)) - 3) + longint'($urandom_range(0, 3)) - 2;
    num = k * longint'(ONE_Q16) + longint'($urandom_range(0, 65535));
    c = coord_t'(num / n);
    return c;
  endfunction

  // Coordinates whose whole footprint has been written; origin as fallback
  function automatic void pick_coords(output coord_t u, output coord_t v);
    for (int tries = 0; tries < 400; tries++) begin
      u = near_seam_coord(cur_w);
      v = near_seam_coord(cur_h);
      if (footprint_written(u, v)) return;
    end
    u = '0;
    v = '0;
  endfunction

  function automatic req_t random_req();
    req_t r;
    coord_t u, v;
    bit compact;
    compact = (cur_w * cur_h <= FILL_LIMIT);
    r.func = ($urandom_range(0, 99) < 30) ? FUNC_WRITE : FUNC_SAMPLE;
    if (compact && $urandom_range(0, 4) != 0) begin
      r.texel_x = xidx_t'($urandom_range(0, cur_w - 1));
      r.texel_y = yidx_t'($urandom_range(0, cur_h - 1));
    end else if (!compact && $urandom_range(0, 1) == 1) begin
      // texels around the store corner: columns and rows 255, 0, 1
      r.texel_x = xidx_t'($urandom_range(MaxWidth - 1, MaxWidth + 1));
      r.texel_y = yidx_t'($urandom_range(MaxHeight - 1, MaxHeight + 1));
    end else begin
      r.texel_x = xidx_t'($urandom);
      r.texel_y = yidx_t'($urandom);
    end
    r.texel = {chan_value(), chan_value(), chan_value()};
    pick_coords(u, v);
    r.coord_u = u;
    r.coord_v = v;
    r.use_texture = ($urandom_range(0, 9) != 0);
    r.scale = {chan_value(), chan_value(), chan_value()};
    return r;
  endfunction

  function automatic logic [InDataBits-1:0] pack_req(req_t r);
    logic [InDataBits-1:0] d;
    d = '0;
    d[7:0]     = r.texel_x;
    d[15:8]    = r.texel_y;
    d[31:16]   = r.texel[0];
    d[47:32]   = r.texel[1];
    d[63:48]   = r.texel[2];
    d[87:64]   = r.coord_u;
    d[111:88]  = r.coord_v;
    d[112]     = r.use_texture;
    d[128:113] = r.scale[0];
    d[144:129] = r.scale[1];
    d[160:145] = r.scale[2];
    return d;
  endfunction

  function automatic void add_write(xidx_t x, yidx_t y, chan_t red, chan_t green, chan_t blue);
    stim_row_t row;
    row.item = '0;
    row.item.func = FUNC_WRITE;
    row.item.texel_x = x;
    row.item.texel_y = y;
    row.item.texel = {blue, green, red};
    row.typed = 1'b0;
    row.result = '0;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void add_sample(coord_t u, coord_t v, logic use_tex, rgb_t scale,
                                     bit typed, rgb_t result);
    stim_row_t row;
    row.item = '0;
    row.item.func = FUNC_SAMPLE;
    row.item.coord_u = u;
    row.item.coord_v = v;
    row.item.use_texture = use_tex;
    row.item.scale = scale;
    row.typed = typed;
    row.result = result;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offer one request from a falling edge; returns at the falling edge after acceptance
  task automatic offer_req(input req_t r, input bit typed, input rgb_t typed_rgb);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_req(r);
    s_axis_tuser  <= r.func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (r.func == FUNC_WRITE) begin
      texel_mem[r.texel_y*MaxWidth + r.texel_x] = r.texel;
      texel_written[r.texel_y*MaxWidth + r.texel_x] = 1'b1;
      n_writes++;
    end else begin
      expected_rgb_q.insert(expected_rgb_q.size(), typed ? typed_rgb : filtered_rgb(r));
      n_samples++;
    end
    @(negedge clk_i);
  endtask

  // Stop sending and wait until the pipeline is empty
  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    while (expected_rgb_q.size() != 0) @(negedge clk_i);
    repeat (PIPE_SETTLE) @(negedge clk_i);
  endtask

  // Write all three registers on consecutive cycles
  task automatic set_config(logic [SizeBits-1:0] w, logic [SizeBits-1:0] h, wrap_e mode);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_TEX_WIDTH;
    cfg_data_i  <= w;
    @(negedge clk_i);
    cfg_index_i <= REG_TEX_HEIGHT;
    cfg_data_i  <= h;
    @(negedge clk_i);
    cfg_index_i <= REG_WRAP_MODE;
    cfg_data_i  <= {{(CfgDataBits-1){1'b0}}, mode};
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_w = eff_size(w, MaxWidth);
    cur_h = eff_size(h, MaxHeight);
    tile_mode = (mode == WRAP_TILE);
  endtask

  // Main sequence
  initial begin : main_seq
    req_t r;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;

    // Corner patch: columns and rows 255, 0, 1, so seam footprints at full size are valid
    add_write(8'd0,   8'd0,   16'h0100, 16'h0200, 16'h0300);
    add_write(8'd1,   8'd0,   16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_write(8'd0,   8'd1,   16'h0000, 16'h0000, 16'h0000);
    add_write(8'd1,   8'd1,   16'h1234, 16'h5678, 16'h9ABC);
    add_write(8'd255, 8'd0,   16'h8000, 16'h4000, 16'h2000);
    add_write(8'd255, 8'd1,   16'h0001, 16'h0002, 16'h0003);
    add_write(8'd0,   8'd255, 16'h7FFF, 16'h8001, 16'h00FF);
    add_write(8'd1,   8'd255, 16'hFF00, 16'h0F0F, 16'hF0F0);
    add_write(8'd255, 8'd255, 16'hABCD, 16'hEF01, 16'h2345);
    // Origin with unit scale returns the texel; full scale saturates; zero scale gives zero
    add_sample(24'h000000, 24'h000000, 1'b1, {3{16'h0100}}, 1'b1,
               {16'h0300, 16'h0200, 16'h0100});
    add_sample(24'h000000, 24'h000000, 1'b1, {3{16'hFFFF}}, 1'b1, {3{16'hFFFF}});
    add_sample(24'h000000, 24'h000000, 1'b1, {3{16'h0000}}, 1'b1, {3{16'h0000}});
    // Texture unused: scale color passes through
    add_sample(24'h800000, 24'h7FFFFF, 1'b0, {16'h8001, 16'hFFFF, 16'h0000}, 1'b1,
               {16'h8001, 16'hFFFF, 16'h0000});
    add_sample(24'h7FFFFF, 24'h800000, 1'b0, {16'hFFFF, 16'h0000, 16'h1234}, 1'b1,
               {16'hFFFF, 16'h0000, 16'h1234});
    // Coordinate extremes, negative floor, half weights, whole-tile offsets
    add_sample(24'h7FFFFF, 24'h800000, 1'b1, {3{16'h0100}}, 1'b0, '0);
    add_sample(24'h800000, 24'h7FFFFF, 1'b1, {3{16'hFFFF}}, 1'b0, '0);
    add_sample(24'hFFFFFF, 24'hFFFFFF, 1'b1, {3{16'h0180}}, 1'b0, '0);
    add_sample(24'h000080, 24'h000080, 1'b1, {3{16'h0100}}, 1'b0, '0);
    add_sample(24'h0000FF, 24'hFFFF01, 1'b1, {16'h0040, 16'h0300, 16'h00FF}, 1'b0, '0);
    add_sample(24'h010000, 24'h020000, 1'b1, {16'h0100, 16'h0080, 16'h0200}, 1'b0, '0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // idling pattern: none, sender, receiver, both
      src_idle_pct   = (p % 4 == 1) ? 77 : (p % 4 == 3) ? 16 : 0;
      sink_stall_pct = (p % 4 == 2) ? 77 : (p % 4 == 3) ? 16 : 0;
      if (p == 0) begin
        foreach (directed_rows[i])
          offer_req(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
      end else begin
        drain_pipe();
        set_config(PHASE_W[p], PHASE_H[p], PHASE_MODE[p]);
      end
      // small textures get every texel written before they are sampled
      if (cur_w * cur_h <= FILL_LIMIT) begin
        for (int y = 0; y < cur_h; y++)
          for (int x = 0; x < cur_w; x++) begin
            r = random_req();
            r.func = FUNC_WRITE;
            r.texel_x = xidx_t'(x);
            r.texel_y = yidx_t'(y);
            offer_req(r, 1'b0, '0);
          end
      end
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        if (p == HOLD_PHASE && i == 20) hold_off_req = 1'b1;
        offer_req(random_req(), 1'b0, '0);
      end
    end
    drain_pipe();

    $display("Run covered %0d texel writes and %0d samples over %0d size and wrap settings,",
             n_writes, n_samples, NUM_PHASES);
    $display("from 1x1 to 256x256 in clamp and tile, with %0d results checked under stalls.",
             n_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : sink_side
    int held;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // Compare each result with the oldest expected color
  always @(posedge clk_i) begin : result_check
    rgb_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_rgb_q.size() == 0) begin
        $display("%0t: result with no sample pending: expected none, actual %h",
                 $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_rgb_q.pop_front();
        n_checked++;
        for (int c = 0; c < NumChan; c++)
          if (m_axis_tdata[c*ChanBits +: ChanBits] !== want[c]) begin
            $display("%0t: out_%s mismatch: expected %h, actual %h", $time, chan_name[c],
                     want[c], m_axis_tdata[c*ChanBits +: ChanBits]);
            errors++;
          end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: %0d results still expected", expected_rgb_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/bts_pkg.sv
rtl/core/bts_coord.sv
rtl/core/bts_texmem.sv
rtl/core/bts_filter.sv
rtl/core/bilinear_texture_sampler_unit.sv
tb/tb.sv
